// File: sv/mtb_pkg.sv
// Shared types, operation codes and helpers for the multi timer bank.
package mtb_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    localparam int OP_W    = 3;
    localparam int TIMER_W = 5;
    localparam int TICK_W  = 32;

    // Stream payload widths, packed from the lowest bit up, padded to bytes
    localparam int IN_FIELDS_W  = OP_W + TIMER_W + TICK_W + 1 + 1 + TICK_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = TIMER_W + 1 + 1 + TICK_W + TICK_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_SET      = 3'd0;
    localparam logic [OP_W-1:0] OP_KILL     = 3'd1;
    localparam logic [OP_W-1:0] OP_KILL_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK    = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // One timer entry as held in the entry memory
    typedef struct packed {
        logic              notify;
        logic [TICK_W-1:0] wrap_mark;
        logic [TICK_W-1:0] reload;
        logic [TICK_W-1:0] deadline;
    } t_entry;

    // Arm a timer: deadline = now + dur mod 2^32, mark now if the sum wrapped
    function automatic t_entry arm_entry(input logic [TICK_W-1:0] now,
                                         input logic [TICK_W-1:0] dur,
                                         input logic              rep,
                                         input logic              nfy);
        t_entry            e;
        logic [TICK_W:0]   sum;
        sum         = {1'b0, now} + {1'b0, dur};
        e.deadline  = sum[TICK_W-1:0];
        e.wrap_mark = sum[TICK_W] ? now : '0;
        e.reload    = rep ? dur : '0;
        e.notify    = nfy;
        return e;
    endfunction

endpackage

// File: sv/multi_timer_bank_top.sv
// Top level of the multi timer bank: request decode, entry memory and expiry scan.
//
// A bank of NUM_TIMERS software timers keyed to a free-running 32-bit tick that
// arrives with every request. Requests are set (one-shot or repeating, a zero
// duration kills), kill, kill all, query and check. Every request answers with
// exactly one status result marked tlast; a check first emits one expiry event
// (tuser = 1) for each notifying timer that fired, in timer order. The block
// works on one request at a time. Set, kill, kill all, query and unknown codes
// go through the execute and status states to the output register. A check goes
// through the execute state, then the scan through the entry memory, which reads,
// tests and writes back one timer per cycle while the output register has room
// for any expiry event, then the status state. A new request is accepted while
// the last result still waits in the output register. Timer deadlines, reloads,
// wrap marks and notify flags live in a single-port-write memory with a
// registered read; the live flags and per-entry written flags are flip-flops,
// so kill all and reset take effect at once and need no sweep.
module multi_timer_bank_top #(
    parameter int NUM_TIMERS = mtb_pkg::NUM_TIMERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // op[2:0], timer_id[7:3], duration[39:8], repeat_req[40],
    // notify_enable[41], now[73:42], zero pad above
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mtb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // event_timer[4:0], ok[5], running[6], deadline_out[38:7],
    // reload_out[70:39], zero pad above
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mtb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TW = mtb_pkg::TICK_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_STAT = 2'd3;

    logic [1:0]                   r_state, n_state;

    // Latched request
    logic [mtb_pkg::OP_W-1:0]     r_op;
    logic [mtb_pkg::TIMER_W-1:0]  r_id;
    logic [TW-1:0]                r_dur;
    logic                         r_rep;
    logic                         r_nfy;
    logic [TW-1:0]                r_now;

    // Timer state outside the memory
    logic [NUM_TIMERS-1:0]        r_live;
    logic [NUM_TIMERS-1:0]        r_written;
    logic [IW-1:0]                r_idx;

    // Entry memory
    mtb_pkg::t_entry              mem [NUM_TIMERS];
    mtb_pkg::t_entry              r_rd;
    logic [IW-1:0]                w_raddr;
    logic                         w_we;
    logic [IW-1:0]                w_waddr;
    mtb_pkg::t_entry              w_wdata;

    // Output register
    logic                         r_m_valid;
    logic [mtb_pkg::OUT_DATA_W-1:0] r_m_data;
    logic                         r_m_user;
    logic                         r_m_last;

    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_valid_id;
    logic [IW-1:0]                w_id_idx;
    logic                         w_skip;
    logic                         w_hit;
    logic                         w_emit;
    logic                         w_adv;
    logic                         w_last_idx;
    logic [mtb_pkg::TIMER_W-1:0]  w_stat_timer;
    logic                         w_stat_ok;
    logic                         w_stat_run;
    logic [TW-1:0]                w_stat_dl;
    logic [TW-1:0]                w_stat_rl;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    // Timer number checks against the bank size; out-of-range numbers touch nothing
    assign w_valid_id = ({1'b0, r_id} < (mtb_pkg::TIMER_W + 1)'(NUM_TIMERS));
    assign w_id_idx   = w_valid_id ? r_id[IW-1:0] : '0;

    // Scan test on the entry read last cycle: live, no pending wrap, deadline reached
    assign w_skip     = (r_rd.wrap_mark != '0) && (r_now >= r_rd.wrap_mark);
    assign w_hit      = r_live[r_idx] && !w_skip && (r_rd.deadline <= r_now);
    assign w_emit     = w_hit && r_rd.notify;
    // Hold the scan while an expiry event has nowhere to go
    assign w_adv      = !w_emit || w_out_free;
    assign w_last_idx = (r_idx == IW'(NUM_TIMERS - 1));

    // Read address: next scan entry, or the addressed timer for query data
    always_comb begin
        w_raddr = w_id_idx;
        if (r_state == S_EXEC && r_op == mtb_pkg::OP_CHECK) begin
            w_raddr = '0;
        end else if (r_state == S_SCAN) begin
            if (!w_adv) begin
                w_raddr = r_idx;
            end else if (w_last_idx) begin
                w_raddr = '0;
            end else begin
                w_raddr = IW'(r_idx + 1'b1);
            end
        end
    end

    // Write port: arm from a set, or re-arm a repeating timer during the scan
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_id_idx;
        w_wdata = mtb_pkg::arm_entry(r_now, r_dur, r_rep, r_nfy);
        if (r_state == S_EXEC && r_op == mtb_pkg::OP_SET && w_valid_id && r_dur != '0) begin
            w_we = 1'b1;
        end else if (r_state == S_SCAN && w_adv && w_hit && r_rd.reload != '0) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = mtb_pkg::arm_entry(r_now, r_rd.reload, 1'b1, r_rd.notify);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[w_raddr];
    end

    // Status result fields; query fields read through the written flags
    always_comb begin
        w_stat_timer = '0;
        w_stat_ok    = 1'b0;
        w_stat_run   = 1'b0;
        w_stat_dl    = '0;
        w_stat_rl    = '0;
        case (r_op)
            mtb_pkg::OP_SET, mtb_pkg::OP_KILL: begin
                w_stat_timer = r_id;
                w_stat_ok    = w_valid_id;
            end
            mtb_pkg::OP_QUERY: begin
                w_stat_timer = r_id;
                w_stat_ok    = w_valid_id;
                if (w_valid_id) begin
                    w_stat_run = r_live[w_id_idx];
                    if (r_written[w_id_idx]) begin
                        w_stat_dl = r_rd.deadline;
                        w_stat_rl = r_rd.reload;
                    end
                end
            end
            mtb_pkg::OP_KILL_ALL, mtb_pkg::OP_CHECK: begin
                w_stat_ok = 1'b1;
            end
            default: begin
                w_stat_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = (r_op == mtb_pkg::OP_CHECK) ? S_SCAN : S_STAT;
            end
            S_SCAN: begin
                if (w_adv && w_last_idx) n_state = S_STAT;
            end
            S_STAT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_written <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_we) begin
                r_written[w_waddr] <= 1'b1;
            end

            // Live flags
            if (r_state == S_EXEC) begin
                case (r_op)
                    mtb_pkg::OP_SET: begin
                        if (w_valid_id) r_live[w_id_idx] <= (r_dur != '0);
                    end
                    mtb_pkg::OP_KILL: begin
                        if (w_valid_id) r_live[w_id_idx] <= 1'b0;
                    end
                    mtb_pkg::OP_KILL_ALL: begin
                        r_live <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (r_state == S_SCAN && w_adv && w_hit) begin
                r_live[r_idx] <= (r_rd.reload != '0);
            end

            // Scan index
            if (r_state == S_EXEC) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN && w_adv && !w_last_idx) begin
                r_idx <= IW'(r_idx + 1'b1);
            end

            // Output register valid
            if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_out_free && ((r_state == S_SCAN && w_emit) || r_state == S_STAT)) begin
                r_m_valid <= 1'b1;
            end
        end
    end

    // Request capture and output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= s_axis_tdata[2:0];
            r_id  <= s_axis_tdata[7:3];
            r_dur <= s_axis_tdata[39:8];
            r_rep <= s_axis_tdata[40];
            r_nfy <= s_axis_tdata[41];
            r_now <= s_axis_tdata[73:42];
        end
        if (w_out_free && r_state == S_SCAN && w_emit) begin
            r_m_user <= mtb_pkg::KIND_EXPIRY;
            r_m_last <= 1'b0;
            r_m_data <= mtb_pkg::OUT_DATA_W'({{TW{1'b0}}, {TW{1'b0}}, 1'b0, 1'b1,
                                              mtb_pkg::TIMER_W'(r_idx)});
        end else if (w_out_free && r_state == S_STAT) begin
            r_m_user <= mtb_pkg::KIND_STATUS;
            r_m_last <= 1'b1;
            r_m_data <= mtb_pkg::OUT_DATA_W'({w_stat_rl, w_stat_dl, w_stat_run,
                                              w_stat_ok, w_stat_timer});
        end
    end

    // An accepted request always goes straight to execution and blocks new input
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC) && !s_axis_tready)
        else $error("accepted request did not enter execution");

    // Kill all leaves no timer running
    a_kill_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == mtb_pkg::OP_KILL_ALL) |=> (r_live == '0))
        else $error("kill all left a timer live");

    // A stalled scan keeps its place and touches no state
    a_scan_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !w_adv) |=> (r_state == S_SCAN) && $stable(r_idx)
                                          && $stable(r_live))
        else $error("scan moved while an expiry event was stalled");

    // A valid set with a nonzero duration leaves the timer live
    a_set_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == mtb_pkg::OP_SET && w_valid_id && r_dur != '0)
        |=> r_live[$past(w_id_idx)])
        else $error("set did not start the timer");

endmodule

// File: verif/multi_timer_bank_top_tb.sv
// Self-checking testbench for the multi timer bank: random streams, timer-bank prediction.
`timescale 1ns / 100ps

// Predicts every result of the timer bank and checks what comes out of it
class timer_bank_scoreboard;

    typedef struct packed {
        logic                        kind;
        logic [mtb_pkg::TIMER_W-1:0] tmr;
        logic                        ok;
        logic                        running;
        logic [mtb_pkg::TICK_W-1:0]  deadline;
        logic [mtb_pkg::TICK_W-1:0]  reload;
        logic                        last;
    } t_timer_result;

    localparam int NT = mtb_pkg::NUM_TIMERS_DEF;

    bit                        timer_live   [NT];
    bit [mtb_pkg::TICK_W-1:0]  timer_dl     [NT];
    bit [mtb_pkg::TICK_W-1:0]  timer_reload [NT];
    bit [mtb_pkg::TICK_W-1:0]  timer_mark   [NT];
    bit                        timer_notify [NT];
    t_timer_result             pending_results[$];
    int unsigned               mismatches;

    function new();
        mismatches = 0;
        for (int i = 0; i < NT; i++) begin
            timer_live[i]   = 1'b0;
            timer_dl[i]     = '0;
            timer_reload[i] = '0;
            timer_mark[i]   = '0;
            timer_notify[i] = 1'b0;
        end
    endfunction

    // deadline = tick + dur mod 2^32; a wrapped sum leaves tick as the wrap mark
    function void arm_timer(int t, bit [31:0] dur, bit rep, bit nfy, bit [31:0] tick);
        bit [32:0] sum;
        sum             = {1'b0, tick} + {1'b0, dur};
        timer_dl[t]     = sum[31:0];
        timer_mark[t]   = sum[32] ? tick : 32'd0;
        timer_reload[t] = rep ? dur : 32'd0;
        timer_notify[t] = nfy;
        timer_live[t]   = 1'b1;
    endfunction

    function void add_result(logic kind, logic [4:0] tmr, logic ok, logic run,
                             logic [31:0] dl, logic [31:0] rl, logic last);
        t_timer_result r;
        r.kind     = kind;
        r.tmr      = tmr;
        r.ok       = ok;
        r.running  = run;
        r.deadline = dl;
        r.reload   = rl;
        r.last     = last;
        pending_results.push_back(r);
    endfunction

    // Apply one accepted request to the timer state and queue its results
    function void note_request(logic [mtb_pkg::IN_DATA_W-1:0] d);
        logic [mtb_pkg::OP_W-1:0]    op;
        logic [mtb_pkg::TIMER_W-1:0] id;
        logic [31:0]                 dur;
        logic [31:0]                 tick;
        logic                        rep;
        logic                        nfy;
        bit                          valid;
        op    = d[2:0];
        id    = d[7:3];
        dur   = d[39:8];
        rep   = d[40];
        nfy   = d[41];
        tick  = d[73:42];
        valid = (id < NT);
        case (op)
            mtb_pkg::OP_SET: begin
                if (valid) begin
                    if (dur == 32'd0)
                        timer_live[id] = 1'b0;
                    else
                        arm_timer(id, dur, rep, nfy, tick);
                end
                add_result(mtb_pkg::KIND_STATUS, id, valid, 1'b0, '0, '0, 1'b1);
            end
            mtb_pkg::OP_KILL: begin
                if (valid)
                    timer_live[id] = 1'b0;
                add_result(mtb_pkg::KIND_STATUS, id, valid, 1'b0, '0, '0, 1'b1);
            end
            mtb_pkg::OP_KILL_ALL: begin
                for (int i = 0; i < NT; i++)
                    timer_live[i] = 1'b0;
                add_result(mtb_pkg::KIND_STATUS, '0, 1'b1, 1'b0, '0, '0, 1'b1);
            end
            mtb_pkg::OP_QUERY: begin
                if (valid)
                    add_result(mtb_pkg::KIND_STATUS, id, 1'b1, timer_live[id],
                               timer_dl[id], timer_reload[id], 1'b1);
                else
                    add_result(mtb_pkg::KIND_STATUS, id, 1'b0, 1'b0, '0, '0, 1'b1);
            end
            mtb_pkg::OP_CHECK: begin
                for (int i = 0; i < NT; i++) begin
                    // skip stopped timers and those still waiting out a wrap
                    if (!timer_live[i])
                        continue;
                    if (timer_mark[i] != 0 && tick >= timer_mark[i])
                        continue;
                    if (timer_dl[i] <= tick) begin
                        if (timer_reload[i] != 0)
                            arm_timer(i, timer_reload[i], 1'b1, timer_notify[i], tick);
                        else
                            timer_live[i] = 1'b0;
                        if (timer_notify[i])
                            add_result(mtb_pkg::KIND_EXPIRY, i[4:0], 1'b1, 1'b0,
                                       '0, '0, 1'b0);
                    end
                end
                add_result(mtb_pkg::KIND_STATUS, '0, 1'b1, 1'b0, '0, '0, 1'b1);
            end
            default: begin
                add_result(mtb_pkg::KIND_STATUS, '0, 1'b0, 1'b0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic kind, logic [mtb_pkg::OUT_DATA_W-1:0] d, logic last);
        t_timer_result got;
        t_timer_result want;
        got.kind     = kind;
        got.tmr      = d[4:0];
        got.ok       = d[5];
        got.running  = d[6];
        got.deadline = d[38:7];
        got.reload   = d[70:39];
        got.last     = last;
        if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual kind=%0b timer=%0d ok=%0b",
                     $time, got.kind, got.tmr, got.ok);
            $display("    running=%0b deadline=%h reload=%h last=%0b",
                     got.running, got.deadline, got.reload, got.last);
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.tmr !== want.tmr || got.ok !== want.ok ||
            got.running !== want.running || got.deadline !== want.deadline ||
            got.reload !== want.reload || got.last !== want.last) begin
            mismatches++;
            $display("%0t: result mismatch", $time);
            $display("    expected kind=%0b timer=%0d ok=%0b running=%0b dl=%h rl=%h last=%0b",
                     want.kind, want.tmr, want.ok, want.running, want.deadline,
                     want.reload, want.last);
            $display("    actual   kind=%0b timer=%0d ok=%0b running=%0b dl=%h rl=%h last=%0b",
                     got.kind, got.tmr, got.ok, got.running, got.deadline,
                     got.reload, got.last);
        end
    endfunction

endclass

module multi_timer_bank_top_tb;

    localparam int NT              = mtb_pkg::NUM_TIMERS_DEF;
    localparam int MAX_ID          = (1 << mtb_pkg::TIMER_W) - 1;
    localparam int RANDOM_REQUESTS = 255;
    localparam int SETTLE_CYCLES   = 2 * NT + 8;
    localparam int WATCHDOG_LIMIT  = 3000;

    // Reserved operation codes sit above the check code
    localparam logic [mtb_pkg::OP_W-1:0] OP_FIRST_RESERVED = 3'd5;

    // Result sink behaviors; each holds for a random stretch of cycles
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SLOW,
        SINK_PERIODIC
    } t_sink_mode;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // op[2:0], timer_id[7:3], duration[39:8], repeat_req[40],
    // notify_enable[41], now[73:42], zero pad above
    logic [mtb_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // event_timer[4:0], ok[5], running[6], deadline_out[38:7],
    // reload_out[70:39], zero pad above
    logic [mtb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // kind[0]
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;

    timer_bank_scoreboard  sb;
    int                    burst_left   = 0;
    int                    sink_left    = 0;
    t_sink_mode            sink_mode    = SINK_OPEN;
    int                    idle_cycles  = 0;

    multi_timer_bank_top #(
        .NUM_TIMERS(NT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Send one request. Called at a falling edge, returns at a falling edge.
    // Requests go out in bursts; between bursts drop tvalid for a random gap,
    // sometimes none at all so back-to-back stretches occur too.
    task automatic send_request(input logic [mtb_pkg::OP_W-1:0]    op,
                                input logic [mtb_pkg::TIMER_W-1:0] id,
                                input logic [31:0]                 dur,
                                input logic                        rep,
                                input logic                        nfy,
                                input logic [31:0]                 tick);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tdata  = {tick, nfy, rep, dur, id, op};
        s_axis_tvalid = 1'b1;
        // hold the request until the block takes it
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(s_axis_tdata);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Result sink: stall on a pattern of its own, changed at every falling edge
    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_left = $urandom_range(8, 48);
        end
        sink_left = sink_left - 1;
        case (sink_mode)
            SINK_OPEN:     m_axis_tready <= 1'b1;
            SINK_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            SINK_SLOW:     m_axis_tready <= ($urandom_range(0, 4) == 0);
            SINK_PERIODIC: m_axis_tready <= (sink_left % 4 == 0);
            default:       m_axis_tready <= 1'b1;
        endcase
    end

    // Sample accepted results at the rising edge and check them in order
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // Watchdog: end the run once nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0]                 tick;
        logic [31:0]                 dur;
        logic [mtb_pkg::TIMER_W-1:0] id;
        logic [mtb_pkg::OP_W-1:0]    op;
        int                          pick;

        sb = new();

        // Hold reset, then release it at a falling edge
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---------------- Directed part ----------------
        // Query a timer straight out of reset: all zero, not running
        send_request(mtb_pkg::OP_QUERY, 5'd0, 32'd0, 1'b0, 1'b0, 32'd0);
        // One-shot notifying, repeating notifying, one-shot silent
        send_request(mtb_pkg::OP_SET, 5'd0, 32'd10, 1'b0, 1'b1, 32'd100);
        send_request(mtb_pkg::OP_SET, 5'd1, 32'd5, 1'b1, 1'b1, 32'd100);
        send_request(mtb_pkg::OP_SET, 5'd2, 32'd3, 1'b0, 1'b0, 32'd100);
        // Largest duration at the largest tick: the sum wraps, mark is set
        send_request(mtb_pkg::OP_SET, 5'(NT - 1), 32'hFFFF_FFFF, 1'b1, 1'b1,
                     32'hFFFF_FFFF);
        // Timer number out of range is rejected
        send_request(mtb_pkg::OP_SET, 5'(MAX_ID), 32'd7, 1'b1, 1'b1, 32'd100);
        // Zero duration acts as a kill
        send_request(mtb_pkg::OP_SET, 5'd3, 32'd0, 1'b1, 1'b1, 32'd100);
        // Repeating timer re-arms, silent one-shot stops without an event
        send_request(mtb_pkg::OP_CHECK, 5'd0, 32'd0, 1'b0, 1'b0, 32'd105);
        send_request(mtb_pkg::OP_QUERY, 5'd1, 32'd0, 1'b0, 1'b0, 32'd105);
        send_request(mtb_pkg::OP_CHECK, 5'd0, 32'd0, 1'b0, 1'b0, 32'd200);
        // Wrapped deadline: skipped while the tick sits at or past the mark
        send_request(mtb_pkg::OP_SET, 5'd4, 32'd100, 1'b0, 1'b1, 32'hFFFF_FFF0);
        send_request(mtb_pkg::OP_CHECK, 5'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFF8);
        send_request(mtb_pkg::OP_CHECK, 5'd0, 32'd0, 1'b0, 1'b0, 32'h0000_0060);
        // Kill clears only the live flag; query shows the stale deadline
        send_request(mtb_pkg::OP_KILL, 5'd1, 32'd0, 1'b0, 1'b0, 32'h0000_0060);
        send_request(mtb_pkg::OP_QUERY, 5'd1, 32'd0, 1'b0, 1'b0, 32'h0000_0060);
        send_request(mtb_pkg::OP_KILL, 5'd20, 32'd0, 1'b0, 1'b0, 32'h0000_0060);
        send_request(mtb_pkg::OP_QUERY, 5'(MAX_ID), 32'd0, 1'b0, 1'b0, 32'h0000_0060);
        // Reserved codes
        send_request(OP_FIRST_RESERVED, 5'd9, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(OP_FIRST_RESERVED + 3'd1, 5'd0, 32'd1, 1'b0, 1'b1, 32'd0);
        send_request(OP_FIRST_RESERVED + 3'd2, 5'(MAX_ID), 32'd0, 1'b1, 1'b0, 32'd1);
        // Kill all, then the wrapped repeating timer is no longer running
        send_request(mtb_pkg::OP_KILL_ALL, 5'(MAX_ID), 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd70);
        send_request(mtb_pkg::OP_QUERY, 5'(NT - 1), 32'd0, 1'b0, 1'b0, 32'd70);
        send_request(mtb_pkg::OP_CHECK, 5'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        // Largest duration from tick zero: no wrap, deadline at the top
        send_request(mtb_pkg::OP_SET, 5'd5, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd0);
        send_request(mtb_pkg::OP_QUERY, 5'd5, 32'd0, 1'b0, 1'b0, 32'd0);

        // ---------------- Random part ----------------
        // The tick mostly creeps forward so short timers fire on later checks;
        // now and then it jumps, parks near the wrap point, or lands anywhere.
        tick = 32'd1000;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                tick = tick + $urandom_range(0, 12);
            else if (pick < 92)
                tick = tick + $urandom_range(13, 300);
            else if (pick < 96)
                tick = 32'hFFFF_FF00 | $urandom_range(0, 255);
            else
                tick = $urandom;

            if ($urandom_range(0, 99) < 85)
                id = 5'($urandom_range(0, NT - 1));
            else
                id = 5'($urandom_range(NT, MAX_ID));

            pick = $urandom_range(0, 99);
            if (pick < 55)
                dur = $urandom_range(1, 40);
            else if (pick < 65)
                dur = 32'd0;
            else if (pick < 80)
                dur = $urandom;
            else if (pick < 90)
                dur = 32'hFFFF_FFFF - $urandom_range(0, 60);
            else
                dur = $urandom_range(41, 1000);

            pick = $urandom_range(0, 99);
            if (pick < 38)
                op = mtb_pkg::OP_SET;
            else if (pick < 68)
                op = mtb_pkg::OP_CHECK;
            else if (pick < 83)
                op = mtb_pkg::OP_QUERY;
            else if (pick < 92)
                op = mtb_pkg::OP_KILL;
            else if (pick < 96)
                op = mtb_pkg::OP_KILL_ALL;
            else
                op = OP_FIRST_RESERVED + 3'($urandom_range(0, 2));

            send_request(op, id, dur, 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 99) < 75), tick);
        end
        s_axis_tvalid = 1'b0;

        // Drain: wait for every predicted result, then watch for strays
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/mtb_pkg.sv
sv/multi_timer_bank_top.sv
verif/multi_timer_bank_top_tb.sv
